/* rtl/core/decimated_mean_square_energy_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimated mean-square energy block
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DECIMATED_MEAN_SQUARE_ENERGY_DEFINES_SVH
`define DECIMATED_MEAN_SQUARE_ENERGY_DEFINES_SVH

`ifndef SYNTHESIS

`define DMSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmse assertion failed (same cycle)");

`define DMSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmse assertion failed (next cycle)");

`else

`define DMSE_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define DMSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/dmse_pkg.sv */
// ----------------------------------------------------------------------------
// Decimated mean-square energy package
// Shared widths, register indexes, sample formats and controller interfaces.
// ----------------------------------------------------------------------------
package dmse_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int SUM_W        = 55;
    localparam int FRAMES_W     = 21;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_FRAMES   = 1048576;
    localparam int POS_W        = $clog2(MAX_CHANNELS);
    localparam int CHAN_W       = 4;
    localparam int PHASE_W      = 8;
    localparam int MAG_W        = 32;
    localparam int SQ_W         = 32;
    localparam int REM_W        = $clog2(MAX_CHANNELS);
    localparam int DIV_STEPS    = SUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 2'd2;

    typedef enum logic [1:0] {
        FMT_FLOAT32 = 2'd0,
        FMT_S16     = 2'd1,
        FMT_S32     = 2'd2,
        FMT_U8      = 2'd3
    } t_format;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last;
        logic div_last;
    } t_ctrl_status;

endpackage

/* rtl/core/dmse_datapath.sv */
// ----------------------------------------------------------------------------
// Decimated mean-square energy datapath
// Sample conversion, squaring, saturating accumulation, frame counting,
// serial division by the channel count and the result register.
// ----------------------------------------------------------------------------
module dmse_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [dmse_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmse_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [dmse_pkg::SAMPLE_W-1:0]     i_sample_bits,
    input  logic                              i_last,
    input  dmse_pkg::t_ctrl_cmd               i_cmd,
    output dmse_pkg::t_ctrl_status            o_status,
    output logic [dmse_pkg::SUM_W-1:0]        o_mean_square,
    output logic [dmse_pkg::FRAMES_W-1:0]     o_sampled_frames
);

    dmse_pkg::t_format                      r_sample_format;
    logic [dmse_pkg::CHAN_W-1:0]            r_channel_count;
    logic [dmse_pkg::PHASE_W-1:0]           r_decimation;

    logic [dmse_pkg::POS_W-1:0]             r_pos;
    logic [dmse_pkg::PHASE_W-1:0]           r_phase;
    logic [dmse_pkg::FRAMES_W-1:0]          r_kept;
    logic [dmse_pkg::SUM_W-1:0]             r_sum;
    logic [dmse_pkg::REM_W-1:0]             r_rem;
    logic [dmse_pkg::DIV_CNT_W-1:0]         r_div_cnt;

    logic [dmse_pkg::MAG_W-1:0]             r_mag;
    logic [dmse_pkg::SQ_W-1:0]              r_sq;
    logic                                   r_keep;
    logic                                   r_last;
    logic [dmse_pkg::SUM_W-1:0]             r_mean_square;
    logic [dmse_pkg::FRAMES_W-1:0]          r_sampled_frames;

    logic [dmse_pkg::CHAN_W-1:0]            chans;
    logic [dmse_pkg::PHASE_W-1:0]           dec;
    logic [dmse_pkg::MAG_W-1:0]             n_mag;
    logic [dmse_pkg::POS_W-1:0]             n_pos;
    logic [dmse_pkg::PHASE_W-1:0]           n_phase;
    logic                                   frame_end;
    logic [2*dmse_pkg::MAG_W-1:0]           product;
    logic [dmse_pkg::SUM_W:0]               sum_add;
    logic [dmse_pkg::CHAN_W-1:0]            div_trial;
    logic                                   div_ge;

    function automatic logic [dmse_pkg::MAG_W-1:0] float_mag(
        input logic [dmse_pkg::SAMPLE_W-1:0] bits
    );
        logic [7:0]                     expo;
        logic [22:0]                    mant;
        logic [dmse_pkg::MAG_W-1:0]     sig;
        logic [7:0]                     lsh;
        logic [7:0]                     rsh;
        logic [dmse_pkg::MAG_W-1:0]     mag;
        expo = bits[30:23];
        mant = bits[22:0];
        sig  = {8'd0, 1'b1, mant};
        lsh  = expo - 8'd119;
        rsh  = 8'd119 - expo;
        if (expo == 8'hFF && mant != 23'd0) begin
            mag = '0;
        end else if (expo == 8'd0) begin
            mag = '0;
        end else if (expo >= 8'd127) begin
            mag = bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (expo >= 8'd119) begin
            mag = sig << lsh[2:0];
        end else if (expo > 8'd87) begin
            mag = sig >> rsh[4:0];
        end else begin
            mag = '0;
        end
        return mag;
    endfunction

    always_comb begin
        chans = r_channel_count;
        if (r_channel_count == '0) begin
            chans = dmse_pkg::CHAN_W'(1);
        end else if (r_channel_count > dmse_pkg::CHAN_W'(dmse_pkg::MAX_CHANNELS)) begin
            chans = dmse_pkg::CHAN_W'(dmse_pkg::MAX_CHANNELS);
        end
        dec = (r_decimation == '0) ? dmse_pkg::PHASE_W'(1) : r_decimation;
    end

    always_comb begin
        logic [15:0] abs16;
        logic [31:0] abs32;
        logic [7:0]  off8;
        logic [7:0]  abs8;
        abs16 = i_sample_bits[15] ? (~i_sample_bits[15:0] + 16'd1) : i_sample_bits[15:0];
        abs32 = i_sample_bits[31] ? (~i_sample_bits + 32'd1) : i_sample_bits;
        off8  = i_sample_bits[7:0] ^ 8'h80;
        abs8  = off8[7] ? (~off8 + 8'd1) : off8;
        unique case (r_sample_format)
            dmse_pkg::FMT_FLOAT32: n_mag = float_mag(i_sample_bits);
            dmse_pkg::FMT_S16:     n_mag = {abs16, 16'd0};
            dmse_pkg::FMT_S32:     n_mag = abs32;
            dmse_pkg::FMT_U8:      n_mag = {abs8, 24'd0};
            default:               n_mag = '0;
        endcase
    end

    always_comb begin
        frame_end = ({1'b0, r_pos} + dmse_pkg::CHAN_W'(1)) >= chans;
        n_pos     = frame_end ? '0 : r_pos + dmse_pkg::POS_W'(1);
        n_phase   = r_phase;
        if (frame_end) begin
            n_phase = (({1'b0, r_phase} + 9'd1) >= {1'b0, dec}) ? '0
                      : r_phase + dmse_pkg::PHASE_W'(1);
        end
    end

    assign product   = r_mag * r_mag;
    assign sum_add   = {1'b0, r_sum} + (dmse_pkg::SUM_W+1)'(r_sq);
    assign div_trial = {r_rem, r_sum[dmse_pkg::SUM_W-1]};
    assign div_ge    = div_trial >= chans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format <= dmse_pkg::FMT_S16;
            r_channel_count <= dmse_pkg::CHAN_W'(1);
            r_decimation    <= dmse_pkg::PHASE_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dmse_pkg::CFG_SAMPLE_FORMAT:
                    r_sample_format <= dmse_pkg::t_format'(i_cfg_data[1:0]);
                dmse_pkg::CFG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[dmse_pkg::CHAN_W-1:0];
                dmse_pkg::CFG_DECIMATION:
                    r_decimation <= i_cfg_data[dmse_pkg::PHASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_phase   <= '0;
            r_kept    <= '0;
            r_sum     <= '0;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pos     <= i_last ? '0 : n_pos;
                r_phase   <= i_last ? '0 : n_phase;
                r_rem     <= '0;
                r_div_cnt <= '0;
                if (r_phase == '0 && r_pos == '0
                    && r_kept < dmse_pkg::FRAMES_W'(dmse_pkg::MAX_FRAMES)) begin
                    r_kept <= r_kept + dmse_pkg::FRAMES_W'(1);
                end
            end
            if (i_cmd.acc && r_keep) begin
                r_sum <= sum_add[dmse_pkg::SUM_W] ? '1 : sum_add[dmse_pkg::SUM_W-1:0];
            end
            if (i_cmd.div_step) begin
                r_sum     <= {r_sum[dmse_pkg::SUM_W-2:0], div_ge};
                r_rem     <= div_ge ? dmse_pkg::REM_W'(div_trial - chans)
                                    : div_trial[dmse_pkg::REM_W-1:0];
                r_div_cnt <= r_div_cnt + dmse_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_sum  <= '0;
                r_kept <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= n_mag;
            r_keep <= (r_phase == '0);
            r_last <= i_last;
        end
        if (i_cmd.mul) begin
            r_sq <= product[2*dmse_pkg::MAG_W-2:dmse_pkg::MAG_W-1];
        end
        if (i_cmd.out_load) begin
            r_mean_square    <= r_sum;
            r_sampled_frames <= r_kept;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.div_last = (r_div_cnt == dmse_pkg::DIV_CNT_W'(dmse_pkg::DIV_STEPS - 1));
    assign o_mean_square     = r_mean_square;
    assign o_sampled_frames  = r_sampled_frames;

endmodule

/* rtl/core/dmse_controller.sv */
// ----------------------------------------------------------------------------
// Decimated mean-square energy controller
// Sequences conversion, squaring, accumulation, division and result handoff.
// ----------------------------------------------------------------------------
module dmse_controller (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  dmse_pkg::t_ctrl_status    i_status,
    output dmse_pkg::t_ctrl_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/decimated_mean_square_energy.sv */
// ----------------------------------------------------------------------------
// Decimated mean-square energy
// Accumulates squared Q1.31 samples of decimated frames and reports the
// per-channel mean square and the kept frame count at the end of each block.
//
//   Channel   Direction   Handshake                    Payload
//   input     in          i_in_valid / o_in_ready      i_sample_bits, i_last
//   result    out         o_out_valid / i_out_ready    o_mean_square,
//                                                      o_sampled_frames
//   config    in          i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// Each sample is accepted and converted, squared, then accumulated before
// the next is accepted. A sample marked last adds the bit-serial divide by the
// channel count and the load of the result register.
// The result register holds a transaction until taken; input is accepted
// while it waits, and only the next block end stalls on it.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`include "decimated_mean_square_energy_defines.svh"

module decimated_mean_square_energy (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [dmse_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmse_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dmse_pkg::SAMPLE_W-1:0]     i_sample_bits,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dmse_pkg::SUM_W-1:0]        o_mean_square,
    output logic [dmse_pkg::FRAMES_W-1:0]     o_sampled_frames
);

    dmse_pkg::t_ctrl_cmd    cmd;
    dmse_pkg::t_ctrl_status status;

    dmse_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dmse_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_bits    (i_sample_bits),
        .i_last           (i_last),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_mean_square    (o_mean_square),
        .o_sampled_frames (o_sampled_frames)
    );

    `DMSE_ASSERT_NEXT(a_accept_then_square, i_clk, i_rst_n, i_in_valid && o_in_ready, cmd.mul)
    `DMSE_ASSERT_NEXT(a_square_then_acc, i_clk, i_rst_n, cmd.mul, cmd.acc)
    `DMSE_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !o_out_valid || i_out_ready)
    `DMSE_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, cmd.out_load, o_out_valid)

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the decimated mean-square energy block
// Streams audio samples through the input channel with random gaps while the
// result channel applies random back pressure. Each accepted sample runs
// through a local energy predictor, and every result transaction is compared
// field by field with the oldest predicted block result. Register settings
// change between phases, and the phases cover the extreme settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_SAMPLES = 1900;
    localparam int QUIET_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] SUM_LIMIT = (64'd1 << dmse_pkg::SUM_W) - 64'd1;
    localparam longint Q31_HIGH = 64'sd2147483647;
    localparam longint Q31_LOW  = -64'sd2147483648;

    typedef struct packed {
        logic [dmse_pkg::SAMPLE_W-1:0] bits;
        logic                          last;
    } t_audio_sample;

    typedef struct packed {
        logic [dmse_pkg::SUM_W-1:0]    mean_square;
        logic [dmse_pkg::FRAMES_W-1:0] frames;
    } t_energy_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [dmse_pkg::CFG_IDX_W-1:0]  i_cfg_index = dmse_pkg::CFG_SAMPLE_FORMAT;
    logic [dmse_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [dmse_pkg::SAMPLE_W-1:0]   i_sample_bits = '0;
    logic                            i_last = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [dmse_pkg::SUM_W-1:0]      o_mean_square;
    logic [dmse_pkg::FRAMES_W-1:0]   o_sampled_frames;

    t_audio_sample  pending_samples[$];
    t_energy_result expected_energy[$];

    dmse_pkg::t_format cfg_format = dmse_pkg::FMT_S16;
    logic [3:0]        cfg_channels = 4'd1;
    logic [7:0]        cfg_decimation = 8'd1;

    int          next_channel = 0;
    int          frame_mod = 0;
    int          frames_kept = 0;
    logic [63:0] energy_sum = '0;

    int             send_gap = 0;
    int             recv_stall = 0;
    bit             send_gapless = 1'b0;
    bit             recv_gapless = 1'b0;
    bit             sample_taken = 1'b0;
    bit             result_taken = 1'b0;
    int             mismatches = 0;
    int             idle_cycles = 0;
    int             recv_draw;
    t_audio_sample  next_sample;
    t_energy_result wanted;

    decimated_mean_square_energy DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_bits    (i_sample_bits),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mean_square    (o_mean_square),
        .o_sampled_frames (o_sampled_frames)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int draw_wait(inout bit gapless);
        if ($urandom_range(0, 31) == 0) gapless = !gapless;
        return gapless ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic int effective_channels(logic [3:0] value);
        if (value == 4'd0) return 1;
        if (value > dmse_pkg::MAX_CHANNELS) return dmse_pkg::MAX_CHANNELS;
        return value;
    endfunction

    function automatic longint sample_to_fixed(logic [dmse_pkg::SAMPLE_W-1:0] bits,
                                               dmse_pkg::t_format fmt);
        int          shift;
        logic [23:0] mant;
        longint      mag;
        case (fmt)
            dmse_pkg::FMT_FLOAT32: begin
                mant  = {1'b1, bits[22:0]};
                shift = int'(bits[30:23]) - 119;
                if (bits[30:23] == 8'hFF && bits[22:0] != 23'd0) return 0;
                if (bits[30:23] == 8'h00) return 0;
                if (shift >= 8) return bits[31] ? Q31_LOW : Q31_HIGH;
                if (shift >= 0) mag = longint'(mant) << shift;
                else if (shift > -32) mag = longint'(mant) >> (-shift);
                else mag = 0;
                return bits[31] ? -mag : mag;
            end
            dmse_pkg::FMT_S16: return longint'($signed(bits[15:0])) * 65536;
            dmse_pkg::FMT_S32: return longint'($signed(bits));
            dmse_pkg::FMT_U8:  return (longint'(bits[7:0]) - 128) * 16777216;
            default: return 0;
        endcase
    endfunction

    function automatic void accumulate_energy(logic [dmse_pkg::SAMPLE_W-1:0] bits, logic last);
        int          chans;
        int          dec;
        longint      fixed_value;
        logic [63:0] mag;
        logic [63:0] square;
        chans = effective_channels(cfg_channels);
        dec   = (cfg_decimation == 8'd0) ? 1 : cfg_decimation;
        if (frame_mod == 0) begin
            fixed_value = sample_to_fixed(bits, cfg_format);
            mag    = (fixed_value < 0) ? -fixed_value : fixed_value;
            square = (mag * mag) >> 31;
            if (next_channel == 0 && frames_kept < dmse_pkg::MAX_FRAMES) frames_kept++;
            if (energy_sum > SUM_LIMIT - square) energy_sum = SUM_LIMIT;
            else energy_sum += square;
        end
        if (next_channel + 1 >= chans) begin
            next_channel = 0;
            frame_mod = (frame_mod + 1 >= dec) ? 0 : frame_mod + 1;
        end else begin
            next_channel++;
        end
        if (last) begin
            expected_energy.push_back('{mean_square: dmse_pkg::SUM_W'(energy_sum / chans),
                                       frames: dmse_pkg::FRAMES_W'(frames_kept)});
            next_channel = 0;
            frame_mod    = 0;
            frames_kept  = 0;
            energy_sum   = '0;
        end
    endfunction

    function automatic logic [dmse_pkg::SAMPLE_W-1:0] random_sample(dmse_pkg::t_format fmt);
        logic [dmse_pkg::SAMPLE_W-1:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 7))
                0:       raw = 32'h0000_0000;
                1:       raw = 32'h7FFF_FFFF;
                2:       raw = 32'h8000_0000;
                3:       raw = 32'hFFFF_FFFF;
                4:       raw = {raw[31:16], 16'h8000};
                5:       raw = {raw[31:8], 8'hFF};
                6:       raw = {raw[31], 8'hFF, raw[22:0]};
                default: raw = {raw[31], 8'h00, raw[22:0]};
            endcase
        end else if (fmt == dmse_pkg::FMT_FLOAT32 && $urandom_range(0, 3) != 0) begin
            raw[30:23] = 8'($urandom_range(96, 127));
        end
        return raw;
    endfunction

    task automatic push_sample(logic [dmse_pkg::SAMPLE_W-1:0] bits, logic last);
        pending_samples.push_back('{bits: bits, last: last});
    endtask

    task automatic write_register(logic [dmse_pkg::CFG_IDX_W-1:0] index, logic [7:0] value);
        logic [7:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        case (index)
            dmse_pkg::CFG_SAMPLE_FORMAT: begin
                i_cfg_data <= {junk[7:2], value[1:0]};
                cfg_format = dmse_pkg::t_format'(value[1:0]);
            end
            dmse_pkg::CFG_CHANNEL_COUNT: begin
                i_cfg_data <= {junk[7:4], value[3:0]};
                cfg_channels = value[3:0];
            end
            default: begin
                i_cfg_data <= value;
                cfg_decimation = value;
            end
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(dmse_pkg::t_format fmt, logic [3:0] chans, logic [7:0] dec);
        write_register(dmse_pkg::CFG_SAMPLE_FORMAT, 8'(fmt));
        write_register(dmse_pkg::CFG_CHANNEL_COUNT, 8'(chans));
        write_register(dmse_pkg::CFG_DECIMATION, dec);
    endtask

    task automatic drain_pipeline();
        while (pending_samples.size() != 0 || i_in_valid || expected_energy.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !sample_taken) begin
            i_in_valid <= 1'b1;
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_samples.size() != 0) begin
            next_sample = pending_samples.pop_front();
            i_in_valid <= 1'b1;
            i_sample_bits <= next_sample.bits;
            i_last <= next_sample.last;
            send_gap <= draw_wait(send_gapless);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (result_taken) begin
            recv_draw = draw_wait(recv_gapless);
            recv_stall <= recv_draw;
            i_out_ready <= (recv_draw == 0);
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            i_out_ready <= (recv_stall == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            sample_taken <= i_in_valid && o_in_ready;
            result_taken <= o_out_valid && i_out_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_energy.size() == 0) begin
                    $error("result transaction with no expected block: mean_square %0d frames %0d",
                           o_mean_square, o_sampled_frames);
                    mismatches++;
                end else begin
                    wanted = expected_energy.pop_front();
                    if (o_mean_square !== wanted.mean_square) begin
                        $error("mean_square expected %0d actual %0d",
                               wanted.mean_square, o_mean_square);
                        mismatches++;
                    end
                    if (o_sampled_frames !== wanted.frames) begin
                        $error("sampled_frames expected %0d actual %0d",
                               wanted.frames, o_sampled_frames);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) accumulate_energy(i_sample_bits, i_last);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int                queued;
        int                blocks;
        int                chans;
        int                total;
        bit                open_end;
        dmse_pkg::t_format fmt;
        logic [3:0]        chan_value;
        logic [7:0]        dec_value;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: signed 16-bit, one channel, no decimation.
        push_sample(32'h0000_7FFF, 1'b0);
        push_sample(32'h0000_8000, 1'b0);
        push_sample(32'hFFFF_0000, 1'b0);
        push_sample(32'h0000_FFFF, 1'b1);
        push_sample(32'h1234_0001, 1'b1);
        drain_pipeline();

        // Float corner values in stereo; the odd count ends on a partial frame.
        configure(dmse_pkg::FMT_FLOAT32, 4'd2, 8'd1);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h807F_FFFF, 1'b0);
        push_sample(32'h7F80_0000, 1'b0);
        push_sample(32'hFF80_0000, 1'b0);
        push_sample(32'hFFC0_0000, 1'b0);
        push_sample(32'h3F80_0000, 1'b0);
        push_sample(32'hBF80_0000, 1'b0);
        push_sample(32'h3F7F_FFFF, 1'b0);
        push_sample(32'hBF00_0000, 1'b0);
        push_sample(32'h2F80_0000, 1'b0);
        push_sample(32'h4000_0000, 1'b0);
        push_sample(32'h3E80_0000, 1'b1);
        drain_pipeline();

        // Zero channel count and zero decimation both act as one.
        configure(dmse_pkg::FMT_S32, 4'd0, 8'd0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        drain_pipeline();

        // Oversized channel count clamps to the maximum; widest decimation.
        configure(dmse_pkg::FMT_U8, 4'd15, 8'd255);
        push_sample(32'hFFFF_FF00, 1'b0);
        push_sample(32'h0000_00FF, 1'b0);
        push_sample(32'h0000_0080, 1'b1);
        drain_pipeline();

        queued = 0;
        while (queued < RANDOM_SAMPLES) begin
            fmt = dmse_pkg::t_format'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0:       chan_value = 4'd1;
                1:       chan_value = 4'd8;
                2:       chan_value = 4'($urandom_range(9, 15));
                3:       chan_value = 4'd0;
                default: chan_value = 4'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 6))
                0:       dec_value = 8'd1;
                1:       dec_value = 8'd255;
                2:       dec_value = 8'd0;
                3:       dec_value = 8'($urandom_range(2, 255));
                default: dec_value = 8'($urandom_range(1, 4));
            endcase
            configure(fmt, chan_value, dec_value);
            chans  = effective_channels(chan_value);
            blocks = $urandom_range(1, 6);
            // An unterminated final block carries its state into the next settings.
            open_end = ($urandom_range(0, 4) == 0);
            for (int b = 0; b < blocks; b++) begin
                total = $urandom_range(1, 12) * chans;
                if ($urandom_range(0, 3) == 0) total += $urandom_range(0, chans - 1);
                for (int s = 0; s < total; s++)
                    push_sample(random_sample(fmt),
                                (s == total - 1) && !(open_end && b == blocks - 1));
                queued += total;
            end
            drain_pipeline();
        end

        if (mismatches == 0 && expected_energy.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
